// ===== rtl/inverse_square_potential_gradient_core_assert.svh =====
// Assertion macros for the inverse-square potential gradient core.
// Used by the top level only; expands to nothing when SYNTHESIS is defined.
`ifndef INVERSE_SQUARE_POTENTIAL_GRADIENT_CORE_ASSERT_SVH
`define INVERSE_SQUARE_POTENTIAL_GRADIENT_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define ISQG_ASSERT_NEVER(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error("isqg: forbidden condition");
`define ISQG_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("isqg: implication failed");
`else
`define ISQG_ASSERT_NEVER(lbl, expr)
`define ISQG_ASSERT_IMPLY(lbl, ante, cons)
`endif
`endif

// ===== rtl/isqg_pkg.sv =====
// Shared types and constants of the inverse-square potential gradient core.
// No dependencies.
`default_nettype none
package isqg_pkg;
    localparam int FRAC_BITS = 16;
    localparam int DIV_STEPS = 32 + 2 * FRAC_BITS;
    localparam int QUO_W     = 47;
    localparam int ACC_W     = QUO_W + 8;
    localparam int GNUM_W    = 33 + FRAC_BITS - 1;
    localparam int GCNT_W    = $clog2(GNUM_W);
    localparam int NUM_POINTS = 7;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [2:0] PT_CENTER = 3'd0;
    localparam logic [2:0] PT_XP     = 3'd1;
    localparam logic [2:0] PT_XM     = 3'd2;
    localparam logic [2:0] PT_YP     = 3'd3;
    localparam logic [2:0] PT_YM     = 3'd4;
    localparam logic [2:0] PT_ZP     = 3'd5;
    localparam logic [2:0] PT_ZM     = 3'd6;

    typedef enum logic [1:0] {
        CFG_ACTIVE   = 2'd0,
        CFG_STEP     = 2'd1,
        CFG_MIN_DIST = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE, S_ISSUE, S_DRAIN, S_GSTART, S_GWAIT, S_FINISH
    } t_state;

    typedef struct packed {
        logic        valid;
        logic [2:0]  pt;
        logic        last;
        logic        skip;
        logic        neg;
        logic [31:0] mag;
    } t_tag;

    typedef struct packed {
        t_tag              tag;
        logic [63:0]       rem;
        logic [63:0]       den;
        logic [QUO_W-1:0]  quo;
        logic              ovf;
    } t_div;
endpackage
`default_nettype wire

// ===== rtl/isqg_in_if.sv =====
// Input channel of the core: valid/ready handshake with the query or write payload.
// No dependencies.
`default_nettype none
interface isqg_in_if;
    logic               valid;
    logic               ready;
    logic               opcode;
    logic [5:0]         entry_index;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] source_weight;
    modport source (output valid, opcode, entry_index, pos_x, pos_y, pos_z,
                    source_weight, input ready);
    modport sink   (input valid, opcode, entry_index, pos_x, pos_y, pos_z,
                    source_weight, output ready);
endinterface
`default_nettype wire

// ===== rtl/isqg_out_if.sv =====
// Result channel of the core: valid/ready handshake with potential and gradient.
// No dependencies.
`default_nettype none
interface isqg_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] potential;
    logic signed [31:0] grad_x;
    logic signed [31:0] grad_y;
    logic signed [31:0] grad_z;
    logic               saturated;
    modport source (output valid, potential, grad_x, grad_y, grad_z, saturated,
                    input ready);
    modport sink   (input valid, potential, grad_x, grad_y, grad_z, saturated,
                    output ready);
endinterface
`default_nettype wire

// ===== rtl/inverse_square_potential_gradient_core.sv =====
// A query runs seven sums that each issue one source term per cycle (at least one)
// into a 64-cell division row, then three serial divisions for the gradient axes.
// Throughput: one query at a time; the result register frees the input early.
// Reset: synchronous, active low; the configuration registers return to 0, 655, 4295.
`default_nettype none
`include "inverse_square_potential_gradient_core_assert.svh"
module inverse_square_potential_gradient_core #(
    parameter int MAX_SOURCES = 64
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_we,
    input  wire logic [1:0]   i_cfg_idx,
    input  wire logic [31:0]  i_cfg_data,
    isqg_in_if.sink           i_in,
    isqg_out_if.source        o_out
);
    import isqg_pkg::*;

    localparam int AW = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;

    function automatic logic [32:0] clamp32(input logic signed [ACC_W-1:0] v);
        if (v > ACC_W'(signed'(33'sh07FFFFFFF)))
            return {1'b1, 32'h7FFFFFFF};
        if (v < -ACC_W'(signed'(33'sh080000000)))
            return {1'b1, 32'h80000000};
        return {1'b0, v[31:0]};
    endfunction

    // configuration
    logic [6:0]  r_active;
    logic [15:0] r_step;
    logic [31:0] r_min;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 7'd0;
            r_step   <= 16'd655;
            r_min    <= 32'd4295;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_ACTIVE:   r_active <= i_cfg_data[6:0];
                CFG_STEP:     r_step   <= i_cfg_data[15:0];
                CFG_MIN_DIST: r_min    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // control
    t_state r_state, n_state;
    logic   w_in_ready, w_issue, w_gd_start, w_out_load;
    logic   w_acc_in, w_wr, w_query, w_last, w_gd_done, w_gd_busy;
    logic   r_evals_done;
    logic [6:0] r_n, r_k, w_n;
    logic [2:0] r_pt;
    logic [1:0] r_axis;
    logic [15:0] w_s;

    assign w_acc_in = i_in.valid && w_in_ready;
    assign w_wr     = w_acc_in && i_in.opcode == OP_WRITE;
    assign w_query  = w_acc_in && i_in.opcode == OP_QUERY;
    assign w_last   = (r_n == 7'd0) || (r_k == r_n - 7'd1);
    assign w_s      = (r_step == 16'd0) ? 16'd1 : r_step;
    assign w_n      = ({25'd0, r_active} > 32'(MAX_SOURCES)) ? 7'(MAX_SOURCES) : r_active;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (w_query) n_state = S_ISSUE;
            S_ISSUE:  if (w_last && r_pt == PT_ZM) n_state = S_DRAIN;
            S_DRAIN:  if (r_evals_done) n_state = S_GSTART;
            S_GSTART: n_state = S_GWAIT;
            S_GWAIT:  if (w_gd_done) n_state = (r_axis == 2'd2) ? S_FINISH : S_GSTART;
            S_FINISH: if (w_out_load) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_in_ready = r_state == S_IDLE;
        w_issue    = r_state == S_ISSUE;
        w_gd_start = r_state == S_GSTART;
        w_out_load = (r_state == S_FINISH) && (!o_out.valid || o_out.ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign i_in.ready = w_in_ready;

    // query point and issue counters
    logic signed [32:0] r_qx, r_qy, r_qz, r_qxp, r_qxm, r_qyp, r_qym, r_qzp, r_qzm;
    logic signed [32:0] w_ix, w_iy, w_iz, w_sx;

    assign w_ix = {i_in.pos_x[31], i_in.pos_x};
    assign w_iy = {i_in.pos_y[31], i_in.pos_y};
    assign w_iz = {i_in.pos_z[31], i_in.pos_z};
    assign w_sx = {17'd0, w_s};

    always_ff @(posedge i_clk) begin
        if (w_query) begin
            r_qx  <= w_ix;         r_qy  <= w_iy;         r_qz  <= w_iz;
            r_qxp <= w_ix + w_sx;  r_qyp <= w_iy + w_sx;  r_qzp <= w_iz + w_sx;
            r_qxm <= w_ix - w_sx;  r_qym <= w_iy - w_sx;  r_qzm <= w_iz - w_sx;
            r_n   <= w_n;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_query) begin
            r_k  <= 7'd0;
            r_pt <= PT_CENTER;
        end else if (w_issue) begin
            if (w_last) begin
                r_k  <= 7'd0;
                r_pt <= r_pt + 3'd1;
            end else begin
                r_k <= r_k + 7'd1;
            end
        end
    end

    // source table
    logic [127:0] r_mem [MAX_SOURCES];
    logic [127:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (w_wr && {26'd0, i_in.entry_index} < 32'(MAX_SOURCES))
            r_mem[AW'(i_in.entry_index)] <= {i_in.source_weight, i_in.pos_z,
                                             i_in.pos_y, i_in.pos_x};
        r_rd <= r_mem[AW'(r_k)];
    end

    // distance pipeline
    t_tag w_ta, r_ta, w_tb, r_tb, r_tc, r_td, r_te;
    logic signed [32:0] w_px, w_py, w_pz;
    logic [33:0] w_dx, w_dy, w_dz, w_ax, w_ay, w_az;
    logic [31:0] r_ax, r_ay, r_az, w_wt;
    logic        r_bx, r_by, r_bz;
    logic [63:0] r_sqx, r_sqy, r_sqz, r_sqz2, r_s1, r_d2;
    logic [64:0] w_s1, w_s2;

    always_comb begin
        w_ta       = '0;
        w_ta.valid = w_issue;
        w_ta.pt    = r_pt;
        w_ta.last  = w_last;
        w_ta.skip  = r_n == 7'd0;
        w_px = (r_ta.pt == PT_XP) ? r_qxp : (r_ta.pt == PT_XM) ? r_qxm : r_qx;
        w_py = (r_ta.pt == PT_YP) ? r_qyp : (r_ta.pt == PT_YM) ? r_qym : r_qy;
        w_pz = (r_ta.pt == PT_ZP) ? r_qzp : (r_ta.pt == PT_ZM) ? r_qzm : r_qz;
        w_dx = {{2{r_rd[31]}}, r_rd[31:0]}  - {w_px[32], w_px};
        w_dy = {{2{r_rd[63]}}, r_rd[63:32]} - {w_py[32], w_py};
        w_dz = {{2{r_rd[95]}}, r_rd[95:64]} - {w_pz[32], w_pz};
        w_ax = w_dx[33] ? -w_dx : w_dx;
        w_ay = w_dy[33] ? -w_dy : w_dy;
        w_az = w_dz[33] ? -w_dz : w_dz;
        w_wt = r_rd[127:96];
        w_tb     = r_ta;
        w_tb.neg = w_wt[31];
        w_tb.mag = w_wt[31] ? -w_wt : w_wt;
        w_s1 = {1'b0, r_sqx} + {1'b0, r_sqy};
        w_s2 = {1'b0, r_s1} + {1'b0, r_sqz2};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ta.valid <= 1'b0;
            r_tb.valid <= 1'b0;
            r_tc.valid <= 1'b0;
            r_td.valid <= 1'b0;
            r_te.valid <= 1'b0;
        end else begin
            r_ta <= w_ta;
            r_tb <= w_tb;
            r_tc <= r_tb;
            r_td <= r_tc;
            r_te <= r_td;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ax   <= w_ax[31:0];  r_bx <= |w_ax[33:32];
        r_ay   <= w_ay[31:0];  r_by <= |w_ay[33:32];
        r_az   <= w_az[31:0];  r_bz <= |w_az[33:32];
        r_sqx  <= r_bx ? '1 : r_ax * r_ax;
        r_sqy  <= r_by ? '1 : r_ay * r_ay;
        r_sqz  <= r_bz ? '1 : r_az * r_az;
        r_s1   <= w_s1[64] ? '1 : w_s1[63:0];
        r_sqz2 <= r_sqz;
        r_d2   <= w_s2[64] ? '1 : w_s2[63:0];
    end

    // division row
    t_div w_dv_in, w_dv_out;

    always_comb begin
        w_dv_in          = '0;
        w_dv_in.tag      = r_te;
        w_dv_in.tag.skip = r_te.skip || (r_d2 <= {32'd0, r_min});
        w_dv_in.den      = r_d2;
    end

    isqg_div_chain u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_d     (w_dv_in),
        .o_d     (w_dv_out)
    );

    // accumulation of the seven sums
    logic signed [ACC_W-1:0] r_acc, r_fin, w_term, w_sum;
    logic [QUO_W-1:0] w_mag;
    logic        r_first, r_fin_v, w_term_sat;
    logic [2:0]  r_fin_pt;
    logic [32:0] w_pcl;
    logic [31:0] r_pval [NUM_POINTS];

    always_comb begin
        w_mag      = w_dv_out.ovf ? '1 : w_dv_out.quo;
        w_term     = w_dv_out.tag.skip ? '0
                   : w_dv_out.tag.neg ? -ACC_W'(w_mag) : ACC_W'(w_mag);
        w_sum      = (r_first ? '0 : r_acc) + w_term;
        w_term_sat = w_dv_out.tag.valid && !w_dv_out.tag.skip && w_dv_out.ovf;
        w_pcl      = clamp32(r_fin);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first      <= 1'b1;
            r_fin_v      <= 1'b0;
            r_evals_done <= 1'b0;
        end else begin
            r_fin_v      <= w_dv_out.tag.valid && w_dv_out.tag.last;
            r_evals_done <= r_fin_v && r_fin_pt == PT_ZM;
            if (w_dv_out.tag.valid)
                r_first <= w_dv_out.tag.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_dv_out.tag.valid) begin
            r_acc    <= w_sum;
            r_fin    <= w_sum;
            r_fin_pt <= w_dv_out.tag.pt;
        end
        if (r_fin_v)
            r_pval[r_fin_pt] <= w_pcl[31:0];
    end

    // central differences
    logic [31:0] w_pa, w_pb;
    logic [32:0] w_gd, w_gm;
    logic        r_gneg;
    logic [GNUM_W-1:0] w_gquo;
    logic signed [GNUM_W:0] w_gval;
    logic [32:0] w_gcl;
    logic [31:0] r_grad [3];

    always_comb begin
        w_pa   = r_pval[3'(2 * r_axis + 1)];
        w_pb   = r_pval[3'(2 * r_axis + 2)];
        w_gd   = {w_pa[31], w_pa} - {w_pb[31], w_pb};
        w_gm   = w_gd[32] ? -w_gd : w_gd;
        w_gval = r_gneg ? -(GNUM_W+1)'(w_gquo) : (GNUM_W+1)'(w_gquo);
        w_gcl  = clamp32(ACC_W'(w_gval));
    end

    isqg_grad_div u_gdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_gd_start),
        .i_num   ({w_gm, (FRAC_BITS-1)'(0)}),
        .i_den   (w_s),
        .o_busy  (w_gd_busy),
        .o_done  (w_gd_done),
        .o_quo   (w_gquo)
    );

    always_ff @(posedge i_clk) begin
        if (w_query)
            r_axis <= 2'd0;
        else if (r_state == S_GWAIT && w_gd_done)
            r_axis <= r_axis + 2'd1;
        if (w_gd_start)
            r_gneg <= w_gd[32];
        if (r_state == S_GWAIT && w_gd_done)
            r_grad[r_axis] <= w_gcl[31:0];
    end

    // saturation flag
    logic r_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sat <= 1'b0;
        end else if (w_query) begin
            r_sat <= 1'b0;
        end else begin
            r_sat <= r_sat | w_term_sat | (r_fin_v && w_pcl[32])
                   | (r_state == S_GWAIT && w_gd_done && w_gcl[32]);
        end
    end

    // result register
    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            o_out.potential <= r_pval[PT_CENTER];
            o_out.grad_x    <= r_grad[0];
            o_out.grad_y    <= r_grad[1];
            o_out.grad_z    <= r_grad[2];
            o_out.saturated <= r_sat;
        end
    end

    assign o_out.valid = r_out_valid;

    `ISQG_ASSERT_NEVER(a_gdiv_restart, w_gd_start && w_gd_busy)
    `ISQG_ASSERT_IMPLY(a_terms_in_query, w_dv_out.tag.valid, r_state == S_ISSUE || r_state == S_DRAIN)
    `ISQG_ASSERT_IMPLY(a_load_from_finish, $rose(r_out_valid), $past(r_state) == S_FINISH)
endmodule
`default_nettype wire

// ===== rtl/isqg_div_cell.sv =====
// One restoring-division cell: produces one quotient bit and hands on the remainder.
// Depends on isqg_pkg.
`default_nettype none
module isqg_div_cell (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  isqg_pkg::t_div     i_d,
    output isqg_pkg::t_div     o_d
);
    import isqg_pkg::*;

    logic        w_bit;
    logic [64:0] w_r2;
    logic [64:0] w_diff;
    logic        w_ge;
    t_div        n_d;
    t_div        r_d;

    always_comb begin
        w_bit  = i_d.tag.mag[31];
        w_r2   = {i_d.rem, w_bit};
        w_diff = w_r2 - {1'b0, i_d.den};
        w_ge   = w_r2 >= {1'b0, i_d.den};
        n_d         = i_d;
        n_d.tag.mag = {i_d.tag.mag[30:0], 1'b0};
        n_d.rem     = w_ge ? w_diff[63:0] : w_r2[63:0];
        n_d.quo     = {i_d.quo[QUO_W-2:0], w_ge};
        n_d.ovf     = i_d.ovf | i_d.quo[QUO_W-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d.tag.valid <= 1'b0;
        end else begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;
endmodule
`default_nettype wire

// ===== rtl/isqg_div_chain.sv =====
// Row of division cells: one source term enters and one leaves every cycle.
// Depends on isqg_pkg and isqg_div_cell.
`default_nettype none
module isqg_div_chain (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  isqg_pkg::t_div i_d,
    output isqg_pkg::t_div o_d
);
    import isqg_pkg::*;

    t_div w_link [DIV_STEPS+1];

    assign w_link[0] = i_d;

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_cell
        isqg_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_d     (w_link[g]),
            .o_d     (w_link[g+1])
        );
    end

    assign o_d = w_link[DIV_STEPS];
endmodule
`default_nettype wire

// ===== rtl/isqg_grad_div.sv =====
// Bit-serial divider for the central difference: one quotient bit per cycle.
// Depends on isqg_pkg.
`default_nettype none
module isqg_grad_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [isqg_pkg::GNUM_W-1:0] i_num,
    input  wire logic [15:0]       i_den,
    output logic                   o_busy,
    output logic                   o_done,
    output logic [isqg_pkg::GNUM_W-1:0] o_quo
);
    import isqg_pkg::*;

    logic [GNUM_W-1:0] r_num;
    logic [GNUM_W-1:0] r_quo;
    logic [15:0]       r_rem;
    logic [15:0]       r_den;
    logic [GCNT_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [16:0]       w_r2;
    logic [16:0]       w_diff;
    logic              w_ge;

    always_comb begin
        w_r2   = {r_rem, r_num[GNUM_W-1]};
        w_diff = w_r2 - {1'b0, r_den};
        w_ge   = w_r2 >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= !i_start && r_busy && r_cnt == GCNT_W'(GNUM_W - 1);
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == GCNT_W'(GNUM_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= '0;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[GNUM_W-2:0], 1'b0};
            r_rem <= w_ge ? w_diff[15:0] : w_r2[15:0];
            r_quo <= {r_quo[GNUM_W-2:0], w_ge};
            r_cnt <= r_cnt + GCNT_W'(1);
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule
`default_nettype wire
